FILE: design/upq_pkg.sv
// Shared constants, command codes and beat types for the unsorted min-priority queue.
package upq_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 8;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [VALUE_W-1:0] value_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] min_value;
		logic                      removed;
		logic                      error;
		logic                      is_empty;
		logic                      is_full;
		logic [COUNT_OUT_W-1:0]    entry_count;
	} out_beat_t;

endpackage

FILE: design/upq_mem.sv
// Entry store: one write port, one read port, read data registered.
module upq_mem #(
	parameter int DEPTH = upq_pkg::CAPACITY_DEF,
	parameter int WIDTH = upq_pkg::VALUE_W,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/unsorted_min_priority_queue.sv
// Top level of the unsorted min-priority queue: command sequencer around the entry store.
//
// Min-priority queue held as an unsorted list of signed 32-bit values in
// insertion order, in a single-port-read, single-port-write RAM. Every input
// beat (clear, insert, remove-min) yields exactly one output beat carrying the
// removed minimum (if any), the error flag and the empty/full/count status
// after the command. Clear, insert and the error cases finish in the cycle the
// beat is taken. A successful remove-min reads every stored entry once to find
// the smallest (earliest one on ties), then reads and rewrites the entries
// after it to close the gap. Both walks are bounded by the one RAM read per
// cycle; after the shift, the done state registers the result once the output
// register is free. The next beat is taken once the block is back in idle with
// its output register free or being drained. Only entries below the count are
// ever read, so the RAM needs no clearing after reset.
module unsorted_min_priority_queue #(
	parameter int CAPACITY = upq_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  upq_pkg::in_beat_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output upq_pkg::out_beat_t out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = upq_pkg::VALUE_W;
	localparam int OW = upq_pkg::COUNT_OUT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;       // next entry to read
	logic               rd_v_s1;     // read data valid this cycle
	logic [AW-1:0]      rd_idx_s1;   // entry the read data came from
	logic signed [VW-1:0] min_q;
	logic [AW-1:0]      pos_q;
	logic               out_valid_q;
	upq_pkg::out_beat_t out_q;

	logic               out_free;
	logic               accept;
	logic               is_full_now;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VW-1:0]      mem_wdata;
	logic               mem_re;
	logic [VW-1:0]      mem_rdata;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE) && out_free;
	assign accept      = in_valid && in_ready;
	assign is_full_now = (count_q == CW'(CAPACITY));
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	// Reads walk the list during scan and shift; one read a cycle.
	assign mem_re = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ptr_q < count_q);

	// Write port: insert appends at the tail; shift moves entry k+1 down to k.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = in_data.value_in;
		if (state_q == ST_SHIFT) begin
			mem_we    = rd_v_s1;
			mem_waddr = rd_idx_s1 - AW'(1);
			mem_wdata = mem_rdata;
		end else if (accept && (in_data.cmd == upq_pkg::CMD_INSERT) && !is_full_now) begin
			mem_we = 1'b1;
		end
	end

	// Status fields for a result reflecting a given count.
	function automatic upq_pkg::out_beat_t status(input logic [CW-1:0] cnt);
		upq_pkg::out_beat_t b;
		logic [CW+OW-1:0]   ext;
		ext           = {{OW{1'b0}}, cnt};
		b             = '0;
		b.is_empty    = (cnt == '0);
		b.is_full     = (cnt == CW'(CAPACITY));
		b.entry_count = ext[OW-1:0];
		return b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			min_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			rd_v_s1   <= mem_re;
			rd_idx_s1 <= ptr_q[AW-1:0];
			if (mem_re) begin
				ptr_q <= ptr_q + CW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						unique case (in_data.cmd)
							upq_pkg::CMD_CLEAR: begin
								count_q <= '0;
								out_q   <= status('0);
							end
							upq_pkg::CMD_INSERT: begin
								if (is_full_now) begin
									out_q       <= status(count_q);
									out_q.error <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
									out_q   <= status(count_q + CW'(1));
								end
							end
							upq_pkg::CMD_REMOVE: begin
								if (count_q == '0) begin
									out_q       <= status(count_q);
									out_q.error <= 1'b1;
								end else begin
									// result is written when the remove completes
									out_valid_q <= 1'b0;
									ptr_q       <= '0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
								out_q       <= status(count_q);
								out_q.error <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// strict less keeps the earliest entry on ties
					if (rd_v_s1 && ((rd_idx_s1 == '0) || ($signed(mem_rdata) < min_q))) begin
						min_q <= $signed(mem_rdata);
						pos_q <= rd_idx_s1;
					end
					if (!mem_re && !rd_v_s1) begin
						ptr_q   <= CW'(pos_q) + CW'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (!mem_re && !rd_v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						count_q         <= count_q - CW'(1);
						out_q           <= status(count_q - CW'(1));
						out_q.min_value <= min_q;
						out_q.removed   <= 1'b1;
						out_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	upq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q[AW-1:0]),
		.rdata (mem_rdata)
	);

endmodule
